[rtl/assert_macros.svh]
// assertion helper macros for the field grid lookup rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define FGTL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("fgtl assertion failed");
// condition must never be true outside reset
`define FGTL_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("fgtl forbidden condition");
`else
`define FGTL_ASSERT(lbl, clk, rst, prop)
`define FGTL_NEVER(lbl, clk, rst, cond)
`endif
`endif

[rtl/fgtl_pkg.sv]
// shared types, constants and helpers of the field grid lookup
`default_nettype none
package fgtl_pkg;

   localparam int GRID_X = 16;
   localparam int GRID_Y = 16;
   localparam int GRID_Z = 16;
   localparam int GRID_MAX = (GRID_X > GRID_Y) ?
                             ((GRID_X > GRID_Z) ? GRID_X : GRID_Z) :
                             ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
   localparam int IW = $clog2(GRID_MAX);
   localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
   localparam int AW = $clog2(CELLS);
   localparam int FW = 24;
   localparam int RND_W = 25;
   localparam int FRAC_W = 12;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_ORIGIN_Z   = 3'd2,
      CSR_INV_STEP_X = 3'd3,
      CSR_INV_STEP_Y = 3'd4,
      CSR_INV_STEP_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                 func;
      logic signed [31:0]   pos_x;
      logic signed [31:0]   pos_y;
      logic signed [31:0]   pos_z;
      logic [3:0]           cell_x;
      logic [3:0]           cell_y;
      logic [3:0]           cell_z;
      logic signed [FW-1:0] field_in_x;
      logic signed [FW-1:0] field_in_y;
      logic signed [FW-1:0] field_in_z;
   } req_type;

   typedef struct packed {
      logic signed [FW-1:0] field_out_x;
      logic signed [FW-1:0] field_out_y;
      logic signed [FW-1:0] field_out_z;
      logic                 in_range;
   } rsp_type;

   typedef struct packed {
      logic signed [FW-1:0] x;
      logic signed [FW-1:0] y;
      logic signed [FW-1:0] z;
   } entry_type;

   // per-axis cell index and fraction from the scaling unit
   typedef struct packed {
      logic                        done;
      logic                        oor;
      logic [2:0]                  neg;
      logic [2:0][IW-1:0]          idx;
      logic [2:0][FRAC_W-1:0]      frac;
   } axis_res_type;

   typedef struct packed {
      logic                   issue;
      logic                   clear;
      logic                   round;
      logic [2:0]             corner;
      logic [2:0][FRAC_W-1:0] frac;
   } blend_ctl_type;

   typedef struct packed {
      logic signed [RND_W-1:0] x;
      logic signed [RND_W-1:0] y;
      logic signed [RND_W-1:0] z;
   } rnd_type;

   // flat entry address, x major and z minor
   function automatic logic [AW-1:0] flat_addr(input logic [IW-1:0] x,
                                               input logic [IW-1:0] y,
                                               input logic [IW-1:0] z);
      return AW'((AW'(x) * AW'(GRID_Y) + AW'(y)) * AW'(GRID_Z) + AW'(z));
   endfunction

endpackage
`default_nettype wire

[rtl/fgtl_grid_ram.sv]
// single-port grid memory with registered read data
`default_nettype none
module fgtl_grid_ram (
   input  wire logic                    clock,
   input  wire logic                    we,
   input  wire logic [fgtl_pkg::AW-1:0] addr,
   input  wire fgtl_pkg::entry_type     wdata,
   output fgtl_pkg::entry_type          rdata
);
   import fgtl_pkg::*;

   entry_type mem [CELLS];
   entry_type rdata_ff;

   // read first port, read data appears in the cycle after the address
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

[rtl/fgtl_axis.sv]
// offset, magnitude and step scaling of the three axes on one shared multiplier
`default_nettype none
module fgtl_axis (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               go,
   input  wire logic [2:0][31:0]   pos,
   input  wire logic [2:0][31:0]   origin,
   input  wire logic [2:0][31:0]   inv_step,
   output fgtl_pkg::axis_res_type  res
);
   import fgtl_pkg::*;

   typedef enum logic [2:0] {A_IDLE, A_ABS, A_LO, A_HI, A_SUM} astate_type;

   localparam int GRID_N [3] = '{GRID_X, GRID_Y, GRID_Z};

   astate_type              state_ff;
   logic [1:0]              ax_ff;
   logic [2:0][32:0]        d_ff;
   logic [2:0][32:0]        mag_ff;
   logic [48:0]             lo_ff;
   logic [48:0]             hi_ff;
   logic [64:0]             s_in;
   logic [40:0]             idx_full;
   logic                    done_ff;
   logic                    oor_ff;
   logic [2:0]              neg_ff;
   logic [2:0][IW-1:0]      idx_ff;
   logic [2:0][FRAC_W-1:0]  frac_ff;

   // full product from the two partial products
   assign s_in     = {16'd0, lo_ff} + {hi_ff, 16'd0};
   assign idx_full = s_in[64:24];

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= A_IDLE;
         ax_ff    <= 2'd0;
         oor_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            A_IDLE: begin
               if (go) begin
                  for (int k = 0; k < 3; k++) begin
                     d_ff[k] <= {pos[k][31], pos[k]} - {origin[k][31], origin[k]};
                  end
                  oor_ff   <= 1'b0;
                  ax_ff    <= 2'd0;
                  state_ff <= A_ABS;
               end
            end
            A_ABS: begin
               for (int k = 0; k < 3; k++) begin
                  neg_ff[k] <= d_ff[k][32];
                  mag_ff[k] <= d_ff[k][32] ? (33'd0 - d_ff[k]) : d_ff[k];
               end
               state_ff <= A_LO;
            end
            A_LO: begin
               lo_ff    <= 49'(mag_ff[ax_ff] * inv_step[ax_ff][15:0]);
               state_ff <= A_HI;
            end
            A_HI: begin
               hi_ff    <= 49'(mag_ff[ax_ff] * inv_step[ax_ff][31:16]);
               state_ff <= A_SUM;
            end
            A_SUM: begin
               idx_ff[ax_ff]  <= s_in[24 +: IW];
               frac_ff[ax_ff] <= s_in[23:12];
               if (idx_full >= 41'(GRID_N[ax_ff] - 1)) begin
                  oor_ff <= 1'b1;
               end
               if (ax_ff == 2'd2) begin
                  done_ff  <= 1'b1;
                  state_ff <= A_IDLE;
               end else begin
                  ax_ff    <= ax_ff + 2'd1;
                  state_ff <= A_LO;
               end
            end
            default: state_ff <= A_IDLE;
         endcase
      end
   end

   assign res.done = done_ff;
   assign res.oor  = oor_ff;
   assign res.neg  = neg_ff;
   assign res.idx  = idx_ff;
   assign res.frac = frac_ff;
endmodule
`default_nettype wire

[rtl/fgtl_blend.sv]
// corner weighting pipeline, accumulator and rounding
`default_nettype none
module fgtl_blend (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fgtl_pkg::blend_ctl_type ctl,
   input  wire fgtl_pkg::entry_type  rd_data,
   output logic                      blend_busy,
   output fgtl_pkg::rnd_type         rnd
);
   import fgtl_pkg::*;

   localparam logic [12:0] W_ONE = 13'd4096;
   localparam logic signed [63:0] HALF = 64'sd34359738368;

   logic [12:0]        wx, wy, wz;
   logic [25:0]        wxy_ff;
   logic [12:0]        wz_ff;
   logic [38:0]        w_full;
   logic [36:0]        w_ff;
   entry_type          dat_ff;
   logic signed [61:0] px_ff, py_ff, pz_ff;
   logic signed [63:0] ax_ff, ay_ff, az_ff;
   logic signed [63:0] sx, sy, sz;
   logic               v1_ff, v2_ff, v3_ff;
   rnd_type            rnd_ff;

   // corner weights per axis
   assign wx = ctl.corner[2] ? {1'b0, ctl.frac[0]} : W_ONE - {1'b0, ctl.frac[0]};
   assign wy = ctl.corner[1] ? {1'b0, ctl.frac[1]} : W_ONE - {1'b0, ctl.frac[1]};
   assign wz = ctl.corner[0] ? {1'b0, ctl.frac[2]} : W_ONE - {1'b0, ctl.frac[2]};
   assign w_full = wxy_ff * wz_ff;

   // valid pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // weight and product stages
   always_ff @(posedge clock) begin
      wxy_ff <= wx * wy;
      wz_ff  <= wz;
      w_ff   <= w_full[36:0];
      dat_ff <= rd_data;
      px_ff  <= $signed({1'b0, w_ff}) * $signed(dat_ff.x);
      py_ff  <= $signed({1'b0, w_ff}) * $signed(dat_ff.y);
      pz_ff  <= $signed({1'b0, w_ff}) * $signed(dat_ff.z);
   end

   // accumulate the eight corner terms
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         ax_ff <= '0;
         ay_ff <= '0;
         az_ff <= '0;
      end else if (v3_ff) begin
         ax_ff <= ax_ff + {{2{px_ff[61]}}, px_ff};
         ay_ff <= ay_ff + {{2{py_ff[61]}}, py_ff};
         az_ff <= az_ff + {{2{pz_ff[61]}}, pz_ff};
      end
   end

   // round to nearest, ties up
   assign sx = ax_ff + HALF;
   assign sy = ay_ff + HALF;
   assign sz = az_ff + HALF;

   always_ff @(posedge clock) begin
      if (ctl.round) begin
         rnd_ff.x <= sx[60:36];
         rnd_ff.y <= sy[60:36];
         rnd_ff.z <= sz[60:36];
      end
   end

   assign blend_busy = v1_ff | v2_ff | v3_ff;
   assign rnd        = rnd_ff;
endmodule
`default_nettype wire

[rtl/field_grid_trilinear_lookup.sv]
// top level: request sequencer, csr bank, grid memory and blend datapath
// write request: accepted while busy is low, no response
// lookup request: one rsp_valid strobe, and the next request can be accepted in the cycle
//   of that strobe (offset, magnitude, low and high multiplier passes and a sum per axis,
//   handoff, 8 corner reads of the single-port grid memory, drain, round, output)
// out-of-range lookup skips the corner reads; strobe is one cycle; reset is synchronous
// reset clears control and origin csrs, presets inv_step; grid undefined until written
`default_nettype none
module field_grid_trilinear_lookup (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire fgtl_pkg::req_type req_data,
   output logic                   rsp_valid,
   output fgtl_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_data
);
   import fgtl_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic [2:0] {
      ST_IDLE, ST_AXIS, ST_ISSUE, ST_DRAIN, ST_ROUND, ST_FINAL
   } state_type;

   state_type         state_ff;
   logic [2:0]        corner_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   logic [2:0][31:0]  origin_ff;
   logic [2:0][31:0]  inv_ff;
   logic [2:0][31:0]  pos;
   logic              accept;
   logic              wr_ok;
   logic              go;
   axis_res_type      axis_res;
   blend_ctl_type     ctl;
   logic              blend_busy;
   rnd_type           rnd;
   entry_type         wdata;
   entry_type         rdata;
   logic              we;
   logic [AW-1:0]     addr;
   logic [IW-1:0]     rx, ry, rz;
   logic [2:0]        flip;
   logic [FW-1:0]     fx_in, fy_in, fz_in;

   // saturating sign correction of one rounded component
   function automatic logic [FW-1:0] fix_sign(input logic signed [RND_W-1:0] v,
                                              input logic f);
      logic signed [RND_W:0] e;
      e = {v[RND_W-1], v};
      if (f) begin
         e = -e;
      end
      if (e > (RND_W+1)'(8388607)) begin
         return FW'(8388607);
      end else if (e < -(RND_W+1)'(8388608)) begin
         return FW'(-8388608);
      end
      return e[FW-1:0];
   endfunction

   assign accept = start & ~busy;
   assign go     = accept & (req_data.func == FUNC_LOOKUP);
   assign wr_ok  = (32'(req_data.cell_x) < 32'(GRID_X)) &&
                   (32'(req_data.cell_y) < 32'(GRID_Y)) &&
                   (32'(req_data.cell_z) < 32'(GRID_Z));
   assign we     = accept & (req_data.func == FUNC_WRITE) & wr_ok;
   assign busy   = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign pos[0] = req_data.pos_x;
   assign pos[1] = req_data.pos_y;
   assign pos[2] = req_data.pos_z;

   // csr bank
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         inv_ff    <= {3{32'h0100_0000}};
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ORIGIN_X:   origin_ff[0] <= csr_data;
            CSR_ORIGIN_Y:   origin_ff[1] <= csr_data;
            CSR_ORIGIN_Z:   origin_ff[2] <= csr_data;
            CSR_INV_STEP_X: inv_ff[0]    <= csr_data;
            CSR_INV_STEP_Y: inv_ff[1]    <= csr_data;
            CSR_INV_STEP_Z: inv_ff[2]    <= csr_data;
            default: ;
         endcase
      end
   end

   fgtl_axis u_axis (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .pos      (pos),
      .origin   (origin_ff),
      .inv_step (inv_ff),
      .res      (axis_res)
   );

   // memory port: corner reads while issuing, writes otherwise
   assign rx = axis_res.idx[0] + IW'(corner_ff[2]);
   assign ry = axis_res.idx[1] + IW'(corner_ff[1]);
   assign rz = axis_res.idx[2] + IW'(corner_ff[0]);
   assign addr = (state_ff == ST_ISSUE) ? flat_addr(rx, ry, rz) :
                 flat_addr(IW'(req_data.cell_x), IW'(req_data.cell_y),
                           IW'(req_data.cell_z));
   assign wdata.x = req_data.field_in_x;
   assign wdata.y = req_data.field_in_y;
   assign wdata.z = req_data.field_in_z;

   fgtl_grid_ram u_ram (
      .clock (clock),
      .we    (we),
      .addr  (addr),
      .wdata (wdata),
      .rdata (rdata)
   );

   assign ctl.issue  = (state_ff == ST_ISSUE);
   assign ctl.clear  = (state_ff == ST_AXIS);
   assign ctl.round  = (state_ff == ST_ROUND);
   assign ctl.corner = corner_ff;
   assign ctl.frac   = axis_res.frac;

   fgtl_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .rd_data    (rdata),
      .blend_busy (blend_busy),
      .rnd        (rnd)
   );

   // mirror symmetry sign flips
   assign flip[0] = axis_res.neg[1];
   assign flip[1] = axis_res.neg[0];
   assign flip[2] = ^axis_res.neg;
   assign fx_in = fix_sign(rnd.x, flip[0]);
   assign fy_in = fix_sign(rnd.y, flip[1]);
   assign fz_in = fix_sign(rnd.z, flip[2]);

   // request sequencer
   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff  <= ST_IDLE;
         corner_ff <= 3'd0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (go) begin
                  state_ff <= ST_AXIS;
               end
            end
            ST_AXIS: begin
               if (axis_res.done) begin
                  corner_ff <= 3'd0;
                  state_ff  <= axis_res.oor ? ST_FINAL : ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               corner_ff <= corner_ff + 3'd1;
               if (corner_ff == 3'd7) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!blend_busy) begin
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               state_ff <= ST_FINAL;
            end
            ST_FINAL: begin
               rsp_valid_ff <= 1'b1;
               if (axis_res.oor) begin
                  rsp_ff <= '0;
               end else begin
                  rsp_ff.field_out_x <= fx_in;
                  rsp_ff.field_out_y <= fy_in;
                  rsp_ff.field_out_z <= fz_in;
                  rsp_ff.in_range    <= 1'b1;
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `FGTL_ASSERT(a_rsp_one_cycle, clock, reset, rsp_valid |=> !rsp_valid)
   `FGTL_ASSERT(a_rsp_after_final, clock, reset, rsp_valid |-> $past(state_ff == ST_FINAL))
   `FGTL_ASSERT(a_oor_zero, clock, reset, (rsp_valid && !rsp_data.in_range) |-> (rsp_data == '0))
   `FGTL_NEVER(a_no_write_busy, clock, reset, we && busy)
endmodule
`default_nettype wire
